/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the glyph decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/rfgd_pkg.sv */
// ----------------------------------------------------------------------------
// rfgd_pkg
// Types, constants and helpers shared by the glyph decoder modules.
// ----------------------------------------------------------------------------
package rfgd_pkg;

  localparam int FIELD_BITS_MAX = 8;
  localparam int COORD_BITS     = 16;
  localparam int DIV_STEPS      = 9;

  // Configuration register indexes
  localparam logic [2:0] CFG_ZERO_RUN = 3'd0;
  localparam logic [2:0] CFG_ONE_RUN  = 3'd1;
  localparam logic [2:0] CFG_WIDTH    = 3'd2;
  localparam logic [2:0] CFG_HEIGHT   = 3'd3;
  localparam logic [2:0] CFG_X_OFF    = 3'd4;
  localparam logic [2:0] CFG_Y_OFF    = 3'd5;
  localparam logic [2:0] CFG_ADVANCE  = 3'd6;

  typedef enum logic [3:0] {
    PH_SIZE, PH_W, PH_H, PH_X, PH_Y, PH_D, PH_A, PH_B, PH_REP
  } phase_e;

  typedef struct packed {
    logic   start_glyph;
    logic   push_byte;
    logic   take;
    phase_e phase;
    logic   load_hdr;
    logic   div_start;
    logic   div_sel_one;
    logic   load_zero;
    logic   load_one;
    logic   commit;
    logic   end_glyph;
  } cmd_t;

  typedef struct packed {
    logic enough;
    logic width_zero;
    logic rep_bit;
    logic div_busy;
    logic glyph_done;
  } sts_t;

  function automatic logic [3:0] clamp_bits(logic [3:0] v);
    return (v > 4'(FIELD_BITS_MAX)) ? 4'(FIELD_BITS_MAX) : v;
  endfunction

  // (1 << cnt) >> 1
  function automatic logic [7:0] bias_of(logic [3:0] cnt);
    logic [8:0] b;
    b = 9'h1 << cnt;
    return b[8:1];
  endfunction

  // (1 << cnt) - 1
  function automatic logic [7:0] field_mask(logic [3:0] cnt);
    logic [8:0] m;
    m = (9'h1 << cnt) - 9'h1;
    return m[7:0];
  endfunction

endpackage

/* hdl/rle_font_glyph_decoder.sv */
// ----------------------------------------------------------------------------
// rle_font_glyph_decoder
// Run-length bitmap font glyph decoder: header result plus one beat per run.
// ----------------------------------------------------------------------------
// Feed one glyph record a byte per beat. Mark the code byte with first_byte;
// that byte also latches start_x/start_y. The code and size bytes are skipped.
// A byte is taken first, then each bit field that it completes, one at a time.
// Then the buffer is found short of the next field and the decoder goes back
// for the next byte; this step is left out when the glyph ends.
// The header beat holds until out_ready takes it.
// Each run pair is worked through in these steps:
// - the two length fields are taken, then the repeat bit;
// - each run then passes through the shared 9-step restoring divider,
//   which wraps the column across the glyph width;
// - each run leaves as a beat of its own;
// - a separate state restarts the divider for the foreground run.
// A repeated pair skips the length fields.
// Only one byte is worked on at a time. The next byte is taken once all
// results of the current one have gone.
// Configuration writes are taken in any cycle and apply from the next field.
module rle_font_glyph_decoder
  import rfgd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  // input bytes
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic [15:0] start_x_i,
  input  logic [15:0] start_y_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  col_o,
  output logic [7:0]  row_o,
  output logic [7:0]  run_len_o,
  output logic        foreground_o,
  output logic [15:0] origin_x_o,
  output logic [15:0] origin_y_o,
  output logic [7:0]  glyph_width_o,
  output logic [7:0]  glyph_height_o,
  output logic signed [7:0] advance_o,
  output logic        glyph_done_o,
  output logic        last_of_item_o
);

  cmd_t       cmd;
  sts_t       sts;
  logic [7:0] adv;

  // registers are always writable
  assign cfg_ready_o = 1'b1;

  rfgd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .first_byte_i (first_byte_i),
    .in_ready_o   (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  rfgd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .data_byte_i    (data_byte_i),
    .start_x_i      (start_x_i),
    .start_y_i      (start_y_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .kind_o         (kind_o),
    .col_o          (col_o),
    .row_o          (row_o),
    .run_len_o      (run_len_o),
    .foreground_o   (foreground_o),
    .origin_x_o     (origin_x_o),
    .origin_y_o     (origin_y_o),
    .glyph_width_o  (glyph_width_o),
    .glyph_height_o (glyph_height_o),
    .advance_o      (adv),
    .glyph_done_o   (glyph_done_o),
    .last_of_item_o (last_of_item_o)
  );

  assign advance_o = signed'(adv);

endmodule

/* hdl/rfgd_div.sv */
// ----------------------------------------------------------------------------
// rfgd_div
// Restoring divider, one quotient bit per cycle, for run position wrapping.
// ----------------------------------------------------------------------------
module rfgd_div
  import rfgd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [8:0] dividend_i,
  input  logic [7:0] divisor_i,
  output logic       busy_o,
  output logic [8:0] quotient_o,
  output logic [7:0] remainder_o
);

  logic [3:0] cnt_q;
  logic [7:0] rem_q, rem_d, dvs_q;
  logic [8:0] quo_q, trial;
  logic       ge;

  always_comb begin
    trial = {rem_q, quo_q[8]};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? 8'(trial - {1'b0, dvs_q}) : trial[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= 4'(DIV_STEPS);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[7:0], ge};
    end
  end

  assign busy_o      = (cnt_q != '0);
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

/* hdl/rfgd_dp.sv */
// ----------------------------------------------------------------------------
// rfgd_dp
// Datapath: configuration, bit buffer, header fields, run position, results.
// ----------------------------------------------------------------------------
module rfgd_dp
  import rfgd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] start_x_i,
  input  logic [15:0] start_y_i,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  output logic        kind_o,
  output logic [7:0]  col_o,
  output logic [7:0]  row_o,
  output logic [7:0]  run_len_o,
  output logic        foreground_o,
  output logic [15:0] origin_x_o,
  output logic [15:0] origin_y_o,
  output logic [7:0]  glyph_width_o,
  output logic [7:0]  glyph_height_o,
  output logic [7:0]  advance_o,
  output logic        glyph_done_o,
  output logic        last_of_item_o
);

  logic [3:0] zb_q, ob_q, wb_q, hb_q, xb_q, yb_q, ab_q;
  logic [15:0] buf_q;
  logic [4:0]  held_q, held_after, pair_bits;
  logic [3:0]  need;
  logic [7:0]  v;
  logic [7:0]  width_q, height_q, rawx_q, rawy_q, adv_q, zlen_q, olen_q, col_q, row_q;
  logic        rep_q;
  logic [COORD_BITS-1:0] sx_q, sy_q, ox_q, oy_q;
  logic [8:0]  dividend, quo;
  logic [7:0]  rem;
  logic        div_busy;
  logic [9:0]  row_sum;
  logic [7:0]  row_new;
  logic        done_one;
  logic        o_kind_q, o_fg_q, o_done_q, o_last_q;
  logic [7:0]  o_col_q, o_row_q, o_len_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zb_q <= 4'd2; ob_q <= 4'd2; wb_q <= 4'd5; hb_q <= 4'd5;
      xb_q <= 4'd4; yb_q <= 4'd4; ab_q <= 4'd5;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ZERO_RUN: zb_q <= cfg_data_i;
        CFG_ONE_RUN:  ob_q <= cfg_data_i;
        CFG_WIDTH:    wb_q <= cfg_data_i;
        CFG_HEIGHT:   hb_q <= cfg_data_i;
        CFG_X_OFF:    xb_q <= cfg_data_i;
        CFG_Y_OFF:    yb_q <= cfg_data_i;
        CFG_ADVANCE:  ab_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cmd_i.phase)
      PH_W:    need = clamp_bits(wb_q);
      PH_H:    need = clamp_bits(hb_q);
      PH_X:    need = clamp_bits(xb_q);
      PH_Y:    need = clamp_bits(yb_q);
      PH_D:    need = clamp_bits(ab_q);
      PH_A:    need = clamp_bits(zb_q);
      PH_B:    need = clamp_bits(ob_q);
      default: need = 4'd1;
    endcase
    v          = buf_q[7:0] & field_mask(need);
    held_after = held_q - {1'b0, need};
    pair_bits  = {1'b0, clamp_bits(zb_q)} + {1'b0, clamp_bits(ob_q)} + 5'd1;
    dividend   = {1'b0, col_q} + {1'b0, (cmd_i.div_sel_one ? olen_q : zlen_q)};
    row_sum    = {2'b0, row_q} + {1'b0, quo};
    row_new    = (row_sum > 10'd255) ? 8'd255 : row_sum[7:0];
    done_one   = !rep_q && (row_new >= height_q);
  end

  rfgd_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (dividend),
    .divisor_i   (width_q),
    .busy_o      (div_busy),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  // Bit buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q  <= '0;
      held_q <= '0;
    end else if (cmd_i.start_glyph || cmd_i.end_glyph) begin
      buf_q  <= '0;
      held_q <= '0;
    end else if (cmd_i.push_byte) begin
      buf_q  <= buf_q | ({8'b0, data_byte_i} << held_q[3:0]);
      held_q <= held_q + 5'd8;
    end else if (cmd_i.take) begin
      buf_q  <= buf_q >> need;
      held_q <= held_after;
    end
  end

  // Fields and position
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_glyph) begin
      sx_q <= COORD_BITS'(start_x_i);
      sy_q <= COORD_BITS'(start_y_i);
    end
    if (cmd_i.take) begin
      unique case (cmd_i.phase)
        PH_W:   width_q  <= v;
        PH_H:   height_q <= v;
        PH_X:   rawx_q   <= v;
        PH_Y:   rawy_q   <= v;
        PH_A:   zlen_q   <= v;
        PH_B:   olen_q   <= v;
        PH_REP: rep_q    <= v[0];
        default: ;
      endcase
    end
    if (cmd_i.load_hdr) begin
      adv_q    <= v - bias_of(clamp_bits(ab_q));
      ox_q     <= sx_q + COORD_BITS'(rawx_q) - COORD_BITS'(bias_of(clamp_bits(xb_q)));
      oy_q     <= sy_q - COORD_BITS'(height_q) - COORD_BITS'(rawy_q)
                  + COORD_BITS'(bias_of(clamp_bits(yb_q)));
      col_q    <= '0;
      row_q    <= '0;
      o_kind_q <= 1'b0;
      o_col_q  <= '0;
      o_row_q  <= '0;
      o_len_q  <= '0;
      o_fg_q   <= 1'b0;
      o_done_q <= (width_q == '0);
      o_last_q <= (width_q == '0) || (held_after < pair_bits);
    end
    if (cmd_i.load_zero) begin
      o_kind_q <= 1'b1;
      o_col_q  <= col_q;
      o_row_q  <= row_q;
      o_len_q  <= zlen_q;
      o_fg_q   <= 1'b0;
      o_done_q <= 1'b0;
      o_last_q <= 1'b0;
    end
    if (cmd_i.load_one) begin
      o_kind_q <= 1'b1;
      o_col_q  <= col_q;
      o_row_q  <= row_q;
      o_len_q  <= olen_q;
      o_fg_q   <= 1'b1;
      o_done_q <= done_one;
      o_last_q <= done_one || (rep_q ? (held_q == '0) : (held_q < pair_bits));
    end
    if (cmd_i.commit) begin
      col_q <= rem;
      row_q <= row_new;
    end
  end

  assign sts_o.enough     = ({1'b0, need} <= held_q);
  assign sts_o.width_zero = (width_q == '0);
  assign sts_o.rep_bit    = rep_q;
  assign sts_o.div_busy   = div_busy;
  assign sts_o.glyph_done = o_done_q;

  assign kind_o         = o_kind_q;
  assign col_o          = o_col_q;
  assign row_o          = o_row_q;
  assign run_len_o      = o_len_q;
  assign foreground_o   = o_fg_q;
  assign origin_x_o     = ox_q[15:0];
  assign origin_y_o     = oy_q[15:0];
  assign glyph_width_o  = width_q;
  assign glyph_height_o = height_q;
  assign advance_o      = adv_q;
  assign glyph_done_o   = o_done_q;
  assign last_of_item_o = o_last_q;

endmodule

/* hdl/rfgd_ctrl.sv */
// ----------------------------------------------------------------------------
// rfgd_ctrl
// Controller: byte intake, field sequencing, run division and result beats.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rfgd_ctrl
  import rfgd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic first_byte_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_BYTE, S_FIELD, S_HDR, S_DIVZ, S_OUTZ, S_STARTO, S_DIVO, S_OUTO
  } state_e;

  state_e state_q, state_d;
  phase_e phase_q, phase_d;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cmd_o   = '0;
    cmd_o.phase = phase_q;
    unique case (state_q)
      S_IDLE, S_BYTE: begin
        if (in_valid_i) begin
          if (first_byte_i) begin
            cmd_o.start_glyph = 1'b1;
            phase_d = PH_SIZE;
            state_d = S_BYTE;
          end else if (state_q == S_BYTE) begin
            // skip the size byte, otherwise append to the bit buffer
            if (phase_q == PH_SIZE) begin
              phase_d = PH_W;
            end else begin
              cmd_o.push_byte = 1'b1;
            end
            state_d = S_FIELD;
          end
        end
      end
      S_FIELD: begin
        if (!sts_i.enough) begin
          state_d = S_BYTE;
        end else begin
          unique case (phase_q)
            PH_W: begin cmd_o.take = 1'b1; phase_d = PH_H; end
            PH_H: begin cmd_o.take = 1'b1; phase_d = PH_X; end
            PH_X: begin cmd_o.take = 1'b1; phase_d = PH_Y; end
            PH_Y: begin cmd_o.take = 1'b1; phase_d = PH_D; end
            PH_D: begin
              cmd_o.take     = 1'b1;
              cmd_o.load_hdr = 1'b1;
              state_d = S_HDR;
            end
            PH_A: begin cmd_o.take = 1'b1; phase_d = PH_B; end
            PH_B: begin cmd_o.take = 1'b1; phase_d = PH_REP; end
            PH_REP: begin
              cmd_o.take      = 1'b1;
              cmd_o.div_start = 1'b1;
              state_d = S_DIVZ;
            end
            default: state_d = S_BYTE;
          endcase
        end
      end
      S_HDR: begin
        if (out_ready_i) begin
          if (sts_i.width_zero) begin
            cmd_o.end_glyph = 1'b1;
            state_d = S_IDLE;
          end else begin
            phase_d = PH_A;
            state_d = S_FIELD;
          end
        end
      end
      S_DIVZ: begin
        if (!sts_i.div_busy) begin
          cmd_o.load_zero = 1'b1;
          state_d = S_OUTZ;
        end
      end
      S_OUTZ: begin
        if (out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d = S_STARTO;
        end
      end
      S_STARTO: begin
        cmd_o.div_start   = 1'b1;
        cmd_o.div_sel_one = 1'b1;
        state_d = S_DIVO;
      end
      S_DIVO: begin
        cmd_o.div_sel_one = 1'b1;
        if (!sts_i.div_busy) begin
          cmd_o.load_one = 1'b1;
          state_d = S_OUTO;
        end
      end
      S_OUTO: begin
        if (out_ready_i) begin
          cmd_o.commit = 1'b1;
          if (sts_i.glyph_done) begin
            cmd_o.end_glyph = 1'b1;
            state_d = S_IDLE;
          end else begin
            phase_d = sts_i.rep_bit ? PH_REP : PH_A;
            state_d = S_FIELD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_SIZE;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE) || (state_q == S_BYTE);
  assign out_valid_o = (state_q == S_HDR) || (state_q == S_OUTZ) || (state_q == S_OUTO);

  `ASSERT_IMPL(a_take_enough, clk_i, rst_ni, cmd_o.take, sts_i.enough)
  `ASSERT_IMPL(a_div_idle, clk_i, rst_ni, cmd_o.div_start, !sts_i.div_busy)
  `ASSERT_NEXT(a_hdr_shown, clk_i, rst_ni, cmd_o.load_hdr, out_valid_o)

endmodule
